### src/gpg_pkg.sv
package gpg_pkg;

	// Palette select codes
	localparam logic [2:0] PAL_RAINBOW   = 3'd0;
	localparam logic [2:0] PAL_NEBULA    = 3'd1;
	localparam logic [2:0] PAL_FIRE      = 3'd2;
	localparam logic [2:0] PAL_BLUEGREEN = 3'd3;
	localparam logic [2:0] PAL_RGBW      = 3'd4;

	localparam int SEG_COUNT = 32;
	localparam int SEG_IDX_W = $clog2(SEG_COUNT);

	// Segment offset/length fit in 6 bits (longest segment has length last-first = 63, 64 entries)
	localparam int OFS_W   = 6;
	// c1*(n-i) + c2*i <= 255*63
	localparam int NUM_W   = 14;
	// floor(num / n) == (num * ceil(2^20 / n)) >> 20 for num < 2^14, n <= 63
	localparam int RCP_SH  = 20;
	localparam int RCP_W   = 16;
	localparam int PROD_W  = NUM_W + RCP_W;

	typedef logic [7:0] chan_t;

	typedef struct packed {
		chan_t r;
		chan_t g;
		chan_t b;
	} rgb_t;

	typedef struct packed {
		logic [2:0] pal;
		logic [7:0] first;
		logic [7:0] last;
		rgb_t       c1;
		rgb_t       c2;
	} seg_t;

	localparam seg_t SEG_TABLE [SEG_COUNT] = '{
		'{PAL_RAINBOW,   8'd0,   8'd35,  '{8'd255, 8'd0,   8'd255}, '{8'd0,   8'd0,   8'd255}},
		'{PAL_RAINBOW,   8'd36,  8'd71,  '{8'd0,   8'd0,   8'd255}, '{8'd0,   8'd255, 8'd255}},
		'{PAL_RAINBOW,   8'd72,  8'd107, '{8'd0,   8'd255, 8'd255}, '{8'd0,   8'd255, 8'd0}},
		'{PAL_RAINBOW,   8'd108, 8'd143, '{8'd0,   8'd255, 8'd0},   '{8'd255, 8'd255, 8'd0}},
		'{PAL_RAINBOW,   8'd144, 8'd179, '{8'd255, 8'd255, 8'd0},   '{8'd255, 8'd127, 8'd0}},
		'{PAL_RAINBOW,   8'd180, 8'd215, '{8'd255, 8'd127, 8'd0},   '{8'd255, 8'd0,   8'd0}},
		'{PAL_RAINBOW,   8'd216, 8'd255, '{8'd255, 8'd0,   8'd0},   '{8'd255, 8'd0,   8'd255}},

		'{PAL_NEBULA,    8'd0,   8'd31,  '{8'd1,   8'd1,   8'd1},   '{8'd0,   8'd0,   8'd127}},
		'{PAL_NEBULA,    8'd32,  8'd95,  '{8'd0,   8'd0,   8'd127}, '{8'd127, 8'd0,   8'd255}},
		'{PAL_NEBULA,    8'd96,  8'd159, '{8'd127, 8'd0,   8'd255}, '{8'd255, 8'd0,   8'd0}},
		'{PAL_NEBULA,    8'd160, 8'd191, '{8'd255, 8'd0,   8'd0},   '{8'd255, 8'd255, 8'd255}},
		'{PAL_NEBULA,    8'd192, 8'd255, '{8'd255, 8'd255, 8'd255}, '{8'd1,   8'd1,   8'd1}},

		'{PAL_FIRE,      8'd0,   8'd23,  '{8'd1,   8'd1,   8'd1},   '{8'd0,   8'd0,   8'd127}},
		'{PAL_FIRE,      8'd24,  8'd47,  '{8'd0,   8'd0,   8'd127}, '{8'd255, 8'd0,   8'd0}},
		'{PAL_FIRE,      8'd48,  8'd95,  '{8'd255, 8'd0,   8'd0},   '{8'd255, 8'd255, 8'd0}},
		'{PAL_FIRE,      8'd96,  8'd127, '{8'd255, 8'd255, 8'd0},   '{8'd255, 8'd255, 8'd255}},
		'{PAL_FIRE,      8'd128, 8'd159, '{8'd255, 8'd255, 8'd255}, '{8'd255, 8'd255, 8'd0}},
		'{PAL_FIRE,      8'd160, 8'd207, '{8'd255, 8'd255, 8'd0},   '{8'd255, 8'd0,   8'd0}},
		'{PAL_FIRE,      8'd208, 8'd231, '{8'd255, 8'd0,   8'd0},   '{8'd0,   8'd0,   8'd127}},
		'{PAL_FIRE,      8'd232, 8'd255, '{8'd0,   8'd0,   8'd127}, '{8'd1,   8'd1,   8'd1}},

		'{PAL_BLUEGREEN, 8'd0,   8'd23,  '{8'd1,   8'd1,   8'd1},   '{8'd0,   8'd0,   8'd127}},
		'{PAL_BLUEGREEN, 8'd24,  8'd47,  '{8'd0,   8'd0,   8'd127}, '{8'd0,   8'd127, 8'd255}},
		'{PAL_BLUEGREEN, 8'd48,  8'd95,  '{8'd0,   8'd127, 8'd255}, '{8'd0,   8'd255, 8'd0}},
		'{PAL_BLUEGREEN, 8'd96,  8'd127, '{8'd0,   8'd255, 8'd0},   '{8'd255, 8'd255, 8'd255}},
		'{PAL_BLUEGREEN, 8'd128, 8'd159, '{8'd255, 8'd255, 8'd255}, '{8'd0,   8'd255, 8'd0}},
		'{PAL_BLUEGREEN, 8'd160, 8'd207, '{8'd0,   8'd255, 8'd0},   '{8'd0,   8'd127, 8'd255}},
		'{PAL_BLUEGREEN, 8'd208, 8'd231, '{8'd0,   8'd127, 8'd255}, '{8'd0,   8'd0,   8'd127}},
		'{PAL_BLUEGREEN, 8'd232, 8'd255, '{8'd0,   8'd0,   8'd127}, '{8'd1,   8'd1,   8'd1}},

		'{PAL_RGBW,      8'd0,   8'd63,  '{8'd1,   8'd1,   8'd1},   '{8'd255, 8'd0,   8'd0}},
		'{PAL_RGBW,      8'd64,  8'd127, '{8'd1,   8'd1,   8'd1},   '{8'd0,   8'd255, 8'd0}},
		'{PAL_RGBW,      8'd128, 8'd191, '{8'd1,   8'd1,   8'd1},   '{8'd0,   8'd0,   8'd255}},
		'{PAL_RGBW,      8'd192, 8'd255, '{8'd1,   8'd1,   8'd1},   '{8'd255, 8'd255, 8'd255}}
	};

	// ceil(2^RCP_SH / n) for every segment length that occurs
	function automatic logic [RCP_W-1:0] recip_of(input logic [OFS_W-1:0] n);
		logic [RCP_W-1:0] m;
		case (n)
			6'd23:   m = 16'd45591;
			6'd31:   m = 16'd33826;
			6'd35:   m = 16'd29960;
			6'd39:   m = 16'd26887;
			6'd47:   m = 16'd22311;
			6'd63:   m = 16'd16645;
			default: m = '0;
		endcase
		return m;
	endfunction

endpackage

### src/gradient_palette_generator.sv
// Pipeline: three registered stages from an input transfer to out_valid (segment
//   select, endpoint blend, reciprocal multiply).
// Throughput: one entry per cycle; the three stages advance together and the
//   whole pipe holds while the output register waits for out_ready.
// Reset: arst_n clears all stage valid bits and sets palette_q to rainbow.
module gradient_palette_generator (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_wr_en,
	input  logic [2:0]           cfg_wr_data,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [7:0]           entry_index,
	output logic                 out_valid,
	input  logic                 out_ready,
	output gpg_pkg::chan_t       red,
	output gpg_pkg::chan_t       green,
	output gpg_pkg::chan_t       blue
);
	import gpg_pkg::*;

	logic [2:0] palette_q;

	logic advance;

	// stage 1: segment found
	logic                 valid_s1;
	logic                 hit_s1;
	logic [OFS_W-1:0]     ofs_s1;
	logic [OFS_W-1:0]     rem_s1;
	logic [RCP_W-1:0]     rcp_s1;
	rgb_t                 c1_s1;
	rgb_t                 c2_s1;

	// stage 2: weighted sums
	logic                 valid_s2;
	logic [NUM_W-1:0]     num_s2 [3];
	logic [RCP_W-1:0]     rcp_s2;

	// stage 3: output register
	logic                 valid_s3;
	chan_t                res_s3 [3];

	// segment search
	logic                 hit;
	logic [SEG_IDX_W-1:0] sel;
	seg_t                 seg;
	logic [7:0]           len;
	logic [7:0]           ofs;

	// Configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			palette_q <= PAL_RAINBOW;
		end else if (cfg_wr_en) begin
			palette_q <= cfg_wr_data;
		end
	end

	// Pipe moves as a whole when the output slot is free or being taken
	assign advance  = !valid_s3 || out_ready;
	assign in_ready = advance;

	// First matching segment wins; scan from the top so lower entries override
	always_comb begin
		hit = 1'b0;
		sel = '0;
		for (int k = SEG_COUNT - 1; k >= 0; k--) begin
			if (SEG_TABLE[k].pal == palette_q && entry_index >= SEG_TABLE[k].first &&
			    entry_index <= SEG_TABLE[k].last) begin
				hit = 1'b1;
				sel = SEG_IDX_W'(k);
			end
		end
		seg = SEG_TABLE[sel];
		len = seg.last - seg.first;
		ofs = entry_index - seg.first;
	end

	// Stage 1
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && in_valid) begin
			hit_s1 <= hit;
			ofs_s1 <= ofs[OFS_W-1:0];
			rem_s1 <= len[OFS_W-1:0] - ofs[OFS_W-1:0];
			rcp_s1 <= recip_of(len[OFS_W-1:0]);
			// unused palette: black endpoints make every channel zero
			c1_s1  <= hit ? seg.c1 : '0;
			c2_s1  <= hit ? seg.c2 : '0;
		end
	end

	// Stage 2: c1*(n-i) + c2*i per channel
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			num_s2[0] <= NUM_W'(c1_s1.r) * NUM_W'(rem_s1) + NUM_W'(c2_s1.r) * NUM_W'(ofs_s1);
			num_s2[1] <= NUM_W'(c1_s1.g) * NUM_W'(rem_s1) + NUM_W'(c2_s1.g) * NUM_W'(ofs_s1);
			num_s2[2] <= NUM_W'(c1_s1.b) * NUM_W'(rem_s1) + NUM_W'(c2_s1.b) * NUM_W'(ofs_s1);
			rcp_s2    <= rcp_s1;
		end
	end

	// Stage 3: floor(num / n) by reciprocal multiply, exact over the numerator range
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (advance) begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s2) begin
			for (int c = 0; c < 3; c++) begin
				res_s3[c] <= chan_t'((PROD_W'(num_s2[c]) * PROD_W'(rcp_s2)) >> RCP_SH);
			end
		end
	end

	assign out_valid = valid_s3;
	assign red       = res_s3[0];
	assign green     = res_s3[1];
	assign blue      = res_s3[2];

	// Stage 2 holding an item always hands it on to stage 3 when the pipe advances
	a_s2_to_s3: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && advance |=> valid_s3)
		else $error("stage 2 item lost on advance");

	// Missed palette lookups must produce black sums
	a_miss_black: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !hit_s1 && advance |=>
			num_s2[0] == '0 && num_s2[1] == '0 && num_s2[2] == '0)
		else $error("unused palette produced nonzero color");

	// Weighted sum stays within the range the reciprocal is exact for
	a_num_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> num_s2[0] <= NUM_W'(16065) && num_s2[1] <= NUM_W'(16065) &&
			num_s2[2] <= NUM_W'(16065))
		else $error("blend numerator out of range");

endmodule

### test/palette_color_checker.sv
module palette_color_checker
	import gpg_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_wr_en,
	input  logic [2:0] cfg_wr_data,
	input  logic       in_valid,
	input  logic       in_ready,
	input  logic [7:0] entry_index,
	input  logic       out_valid,
	input  logic       out_ready,
	input  chan_t      red,
	input  chan_t      green,
	input  chan_t      blue,
	output int         fail_count,
	output int         colors_pending
);
	timeunit 1ns;
	timeprecision 1ps;

	// One linear ramp of a palette: entries lo..hi blend from one color to another
	typedef struct packed {
		logic [2:0] pal;
		logic [7:0] lo;
		logic [7:0] hi;
		rgb_t       from;
		rgb_t       to;
	} ramp_t;

	localparam int RAMP_COUNT = 32;

	localparam ramp_t RAMPS [RAMP_COUNT] = '{
		'{PAL_RAINBOW,     0,  35, '{255,   0, 255}, '{  0,   0, 255}},
		'{PAL_RAINBOW,    36,  71, '{  0,   0, 255}, '{  0, 255, 255}},
		'{PAL_RAINBOW,    72, 107, '{  0, 255, 255}, '{  0, 255,   0}},
		'{PAL_RAINBOW,   108, 143, '{  0, 255,   0}, '{255, 255,   0}},
		'{PAL_RAINBOW,   144, 179, '{255, 255,   0}, '{255, 127,   0}},
		'{PAL_RAINBOW,   180, 215, '{255, 127,   0}, '{255,   0,   0}},
		'{PAL_RAINBOW,   216, 255, '{255,   0,   0}, '{255,   0, 255}},
		'{PAL_NEBULA,      0,  31, '{  1,   1,   1}, '{  0,   0, 127}},
		'{PAL_NEBULA,     32,  95, '{  0,   0, 127}, '{127,   0, 255}},
		'{PAL_NEBULA,     96, 159, '{127,   0, 255}, '{255,   0,   0}},
		'{PAL_NEBULA,    160, 191, '{255,   0,   0}, '{255, 255, 255}},
		'{PAL_NEBULA,    192, 255, '{255, 255, 255}, '{  1,   1,   1}},
		'{PAL_FIRE,        0,  23, '{  1,   1,   1}, '{  0,   0, 127}},
		'{PAL_FIRE,       24,  47, '{  0,   0, 127}, '{255,   0,   0}},
		'{PAL_FIRE,       48,  95, '{255,   0,   0}, '{255, 255,   0}},
		'{PAL_FIRE,       96, 127, '{255, 255,   0}, '{255, 255, 255}},
		'{PAL_FIRE,      128, 159, '{255, 255, 255}, '{255, 255,   0}},
		'{PAL_FIRE,      160, 207, '{255, 255,   0}, '{255,   0,   0}},
		'{PAL_FIRE,      208, 231, '{255,   0,   0}, '{  0,   0, 127}},
		'{PAL_FIRE,      232, 255, '{  0,   0, 127}, '{  1,   1,   1}},
		'{PAL_BLUEGREEN,   0,  23, '{  1,   1,   1}, '{  0,   0, 127}},
		'{PAL_BLUEGREEN,  24,  47, '{  0,   0, 127}, '{  0, 127, 255}},
		'{PAL_BLUEGREEN,  48,  95, '{  0, 127, 255}, '{  0, 255,   0}},
		'{PAL_BLUEGREEN,  96, 127, '{  0, 255,   0}, '{255, 255, 255}},
		'{PAL_BLUEGREEN, 128, 159, '{255, 255, 255}, '{  0, 255,   0}},
		'{PAL_BLUEGREEN, 160, 207, '{  0, 255,   0}, '{  0, 127, 255}},
		'{PAL_BLUEGREEN, 208, 231, '{  0, 127, 255}, '{  0,   0, 127}},
		'{PAL_BLUEGREEN, 232, 255, '{  0,   0, 127}, '{  1,   1,   1}},
		'{PAL_RGBW,        0,  63, '{  1,   1,   1}, '{255,   0,   0}},
		'{PAL_RGBW,       64, 127, '{  1,   1,   1}, '{  0, 255,   0}},
		'{PAL_RGBW,      128, 191, '{  1,   1,   1}, '{  0,   0, 255}},
		'{PAL_RGBW,      192, 255, '{  1,   1,   1}, '{255, 255, 255}}
	};

	logic [2:0] pal_sel;
	rgb_t       colors_due [$];
	rgb_t       want;

	initial begin
		fail_count     = 0;
		colors_pending = 0;
	end

	// exact floor of the weighted mean of two end colors
	function automatic chan_t ramp_channel(input int c1, input int c2, input int i, input int n);
		int v;
		v = (c1 * (n - i) + c2 * i) / n;
		return v[7:0];
	endfunction

	// color of one entry; spare palette codes match no ramp and give black
	function automatic rgb_t palette_color(input logic [2:0] pal, input logic [7:0] idx);
		rgb_t c;
		int   n;
		int   i;
		bit   hit;
		c   = '0;
		hit = 1'b0;
		for (int k = 0; k < RAMP_COUNT; k++) begin
			if (!hit && RAMPS[k].pal == pal && idx >= RAMPS[k].lo && idx <= RAMPS[k].hi) begin
				hit = 1'b1;
				n   = int'(RAMPS[k].hi) - int'(RAMPS[k].lo);
				i   = int'(idx) - int'(RAMPS[k].lo);
				c.r = ramp_channel(int'(RAMPS[k].from.r), int'(RAMPS[k].to.r), i, n);
				c.g = ramp_channel(int'(RAMPS[k].from.g), int'(RAMPS[k].to.g), i, n);
				c.b = ramp_channel(int'(RAMPS[k].from.b), int'(RAMPS[k].to.b), i, n);
			end
		end
		return c;
	endfunction

	task automatic report_mismatch(input string what, input int got, input int exp_val);
		$display("%0t: %s mismatch: got %0d, expected %0d", $realtime, what, got, exp_val);
		fail_count = fail_count + 1;
	endtask

	// compare output transfers in order, queue a color per input transfer
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pal_sel <= PAL_RAINBOW;
			colors_due.delete();
			colors_pending = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (colors_due.size() == 0) begin
					report_mismatch("unexpected output transfer", 1, 0);
				end else begin
					want = colors_due.pop_front();
					if (red !== want.r)
						report_mismatch("red", int'(red), int'(want.r));
					if (green !== want.g)
						report_mismatch("green", int'(green), int'(want.g));
					if (blue !== want.b)
						report_mismatch("blue", int'(blue), int'(want.b));
				end
			end
			if (in_valid && in_ready)
				colors_due.push_back(palette_color(pal_sel, entry_index));
			if (cfg_wr_en)
				pal_sel <= cfg_wr_data;
			colors_pending = colors_due.size();
		end
	end

endmodule

### test/tb_top.sv
module tb_top;
	import gpg_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	// palette codes with no ramps behind them
	localparam logic [2:0] PAL_SPARE_LO  = 3'd5;
	localparam logic [2:0] PAL_SPARE_MID = 3'd6;
	localparam logic [2:0] PAL_SPARE_HI  = 3'd7;

	localparam int PHASE_COUNT     = 13;
	localparam int ITEMS_PER_PHASE = 50;
	localparam int HOLD_PERIOD     = 400;
	localparam int HOLD_CYCLES     = 48;

	typedef enum int {RX_ALWAYS, RX_COIN, RX_SPARSE, RX_PERIODIC} rx_mode_t;

	// ramp ends of the rainbow palette plus a few interior points
	localparam logic [7:0] RAMP_ENDS [17] = '{
		0, 35, 36, 71, 72, 107, 108, 143, 144, 179, 180, 215, 216, 255, 1, 128, 254
	};

	localparam logic [2:0] PHASE_PAL [PHASE_COUNT - 1] = '{
		PAL_NEBULA, PAL_FIRE, PAL_BLUEGREEN, PAL_RGBW, PAL_RAINBOW, PAL_SPARE_LO,
		PAL_SPARE_MID, PAL_RGBW, PAL_FIRE, PAL_NEBULA, PAL_BLUEGREEN, PAL_RAINBOW
	};

	logic       clk = 1'b0;
	logic       arst_n;
	logic       cfg_wr_en;
	logic [2:0] cfg_wr_data;
	logic       in_valid;
	logic       in_ready;
	logic [7:0] entry_index;
	logic       out_valid;
	logic       out_ready;
	chan_t      red;
	chan_t      green;
	chan_t      blue;
	int         fail_count;
	int         colors_pending;
	int         burst_left;

	gradient_palette_generator u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.entry_index (entry_index),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.red         (red),
		.green       (green),
		.blue        (blue)
	);

	palette_color_checker u_color_chk (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_wr_en      (cfg_wr_en),
		.cfg_wr_data    (cfg_wr_data),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.entry_index    (entry_index),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.red            (red),
		.green          (green),
		.blue           (blue),
		.fail_count     (fail_count),
		.colors_pending (colors_pending)
	);

	always begin
		clk = 1'b0;
		#1;
		clk = 1'b1;
		#1;
	end

	// offer one entry, hold it until transfer, then maybe idle between bursts
	task automatic offer_entry(input logic [7:0] idx);
		int gap;
		in_valid    <= 1'b1;
		entry_index <= idx;
		do
			@(posedge clk);
		while (!in_ready);
		@(negedge clk);
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			burst_left = $urandom_range(0, 20);
			gap        = $urandom_range(0, 6);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
	endtask

	// register write once every queued color has come out
	task automatic select_palette(input logic [2:0] pal);
		in_valid <= 1'b0;
		while (colors_pending != 0)
			@(negedge clk);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= pal;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	// receiver: out_ready follows a ready mode redrawn at random, with a long hold-off now and then
	initial begin
		int       cyc;
		int       hold_left;
		rx_mode_t rx_mode;
		cyc       = 0;
		hold_left = 0;
		rx_mode   = RX_ALWAYS;
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			cyc++;
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else if (cyc % HOLD_PERIOD == 50) begin
				hold_left = HOLD_CYCLES - 1;
				out_ready <= 1'b0;
			end else begin
				if (cyc % 64 == 0)
					rx_mode = rx_mode_t'($urandom_range(0, 3));
				case (rx_mode)
					RX_ALWAYS:   out_ready <= 1'b1;
					RX_COIN:     out_ready <= 1'($urandom_range(0, 1));
					RX_SPARSE:   out_ready <= ($urandom_range(0, 3) == 0);
					RX_PERIODIC: out_ready <= (cyc % 5 != 2);
					default:     out_ready <= 1'b1;
				endcase
			end
		end
	end

	// stimulus and verdict
	initial begin
		arst_n      = 1'b0;
		cfg_wr_en   = 1'b0;
		cfg_wr_data = PAL_RAINBOW;
		in_valid    = 1'b0;
		entry_index = '0;
		burst_left  = 0;
		repeat (5) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: rainbow ramp ends under the reset palette
		foreach (RAMP_ENDS[k])
			offer_entry(RAMP_ENDS[k]);

		// directed: spare palette code gives black
		select_palette(PAL_SPARE_HI);
		offer_entry(8'd0);
		offer_entry(8'd255);
		offer_entry(8'h55);
		offer_entry(8'haa);

		// random entries over a sequence of palettes, the last one random
		for (int p = 0; p < PHASE_COUNT; p++) begin
			if (p < PHASE_COUNT - 1)
				select_palette(PHASE_PAL[p]);
			else
				select_palette(3'($urandom_range(0, 7)));
			repeat (ITEMS_PER_PHASE)
				offer_entry(8'($urandom_range(0, 255)));
		end

		in_valid <= 1'b0;
		while (colors_pending != 0)
			@(negedge clk);
		repeat (8) @(negedge clk);
		if (fail_count == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

	// run limit
	initial begin
		#500us;
		$display("TEST FAILED");
		$finish;
	end

endmodule
